[src/metric_slot_aggregator_top_assert.svh]
// Assertion macros for the metric slot aggregator.
// Each macro takes a label, an antecedent and a consequent.
`ifndef METRIC_SLOT_AGGREGATOR_TOP_ASSERT_SVH
`define METRIC_SLOT_AGGREGATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("metric slot aggregator check failed");
`define MSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("metric slot aggregator check failed");
`else
`define MSA_ASSERT_SAME(label, ante, cons)
`define MSA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[src/msa_pkg.sv]
`default_nettype none
package msa_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        name_key;
    logic signed [63:0] amount;
  } in_beat_t;

  typedef struct packed {
    logic               accepted;
    logic [3:0]         slot_index;
    logic signed [63:0] slot_value;
    logic [31:0]        drop_total;
    logic               table_empty;
  } out_beat_t;

endpackage
`default_nettype wire

[src/msa_in_if.sv]
`default_nettype none
interface msa_in_if;
  import msa_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/msa_out_if.sv]
`default_nettype none
interface msa_out_if;
  import msa_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/msa_ram.sv]
`default_nettype none
module msa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/metric_slot_aggregator_top.sv]
// Metric slot aggregator.
// The req channel carries one update beat: op (counter add, gauge set or
// clear), name_key and a signed 64-bit amount. The rsp channel returns one
// beat per request with the accepted flag, slot index, slot value, drop
// total and table empty flag. Both channels use valid and ready.
// A counter add or gauge set scans the key store one slot per cycle through
// a single registered-read RAM port and stops at the first match. The rsp
// beat is built step by step after acceptance: a decode, a scan through the
// read latency, a decision on a free slot or a drop if nothing matched, a
// write of the slot, and a load of the output register. A hit goes from
// the scan straight to the write, and a drop on a full table skips the write.
// A clear or an unused op code goes from the decode to the output register.
// One request is in work at a time; req.ready is high only while idle, so
// a request is taken only after the one before has finished.
// The rsp beat sits in an output register, so a new request is taken while
// a finished beat waits; if the receiver stalls, the next beat waits in the
// block until the register frees, and req.ready stays low meanwhile.
// Reset empties the table and zeroes the drop count at once; slot contents
// are only read for slots marked in use, so the RAM needs no clearing.
`default_nettype none
module metric_slot_aggregator_top #(
  parameter int SLOTS    = msa_pkg::SLOTS_DEF,
  parameter int KEY_BITS = msa_pkg::KEY_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  msa_in_if.sink   req,
  msa_out_if.source rsp
);
  import msa_pkg::*;

`include "metric_slot_aggregator_top_assert.svh"

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int RW = 1 + KW + 64;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_WRITE  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]         state;
  logic [1:0]         op_r;
  logic [KW-1:0]      key_r;
  logic               gauge_r;
  logic signed [63:0] amount_r;
  logic [SLOTS-1:0]   in_use;
  logic [CW-1:0]      used_cnt;
  logic [31:0]        drop;
  logic [CW-1:0]      scan_cnt;
  logic               chk_vld;
  logic [IW-1:0]      chk_idx;
  logic               have_free;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      hit_idx;
  logic               claim;
  logic signed [63:0] base;
  logic               res_acc;
  logic [IW-1:0]      res_idx;
  logic signed [63:0] res_val;
  logic               out_vld;
  out_beat_t          out_data;
  logic               fin_go;

  logic               ram_re;
  logic               ram_we;
  logic [IW-1:0]      ram_raddr;
  logic [RW-1:0]      ram_wdata;
  logic [RW-1:0]      ram_rdata;
  logic               rd_gauge;
  logic [KW-1:0]      rd_key;
  logic signed [63:0] rd_total;
  logic               hit_now;
  logic               free_now;
  logic signed [63:0] new_total;
  logic [IW+3:0]      res_idx_ext;

  msa_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_re      = (state == ST_SCAN) && (scan_cnt < SLOTS_C);
    ram_raddr   = scan_cnt[IW-1:0];
    rd_gauge    = ram_rdata[KW+64];
    rd_key      = ram_rdata[KW+63:64];
    rd_total    = ram_rdata[63:0];
    hit_now     = chk_vld && in_use[chk_idx] && (rd_gauge == gauge_r) && (rd_key == key_r);
    free_now    = chk_vld && !in_use[chk_idx];
    new_total   = gauge_r ? amount_r : base + amount_r;
    ram_we      = (state == ST_WRITE);
    ram_wdata   = {gauge_r, key_r, new_total};
    res_idx_ext = {4'b0000, res_idx};
    fin_go      = (state == ST_FINISH) && (!out_vld || rsp.ready);
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_vld;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_use   <= '0;
      used_cnt <= '0;
      drop     <= '0;
      out_vld  <= 1'b0;
      chk_vld  <= 1'b0;
    end else begin
      if (fin_go) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op_r     <= req.data.op;
            key_r    <= req.data.name_key[KW-1:0];
            amount_r <= req.data.amount;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          gauge_r   <= (op_r == OP_SET);
          res_acc   <= 1'b0;
          res_idx   <= '0;
          res_val   <= '0;
          scan_cnt  <= '0;
          chk_vld   <= 1'b0;
          have_free <= 1'b0;
          case (op_r)
            OP_CLEAR: begin
              in_use   <= '0;
              used_cnt <= '0;
              drop     <= '0;
              res_acc  <= 1'b1;
              state    <= ST_FINISH;
            end
            OP_NONE: begin
              state <= ST_FINISH;
            end
            default: begin
              state <= ST_SCAN;
            end
          endcase
        end
        ST_SCAN: begin
          if (hit_now) begin
            hit_idx <= chk_idx;
            base    <= rd_total;
            claim   <= 1'b0;
            chk_vld <= 1'b0;
            state   <= ST_WRITE;
          end else begin
            if (free_now && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= chk_idx;
            end
            chk_vld <= ram_re;
            chk_idx <= scan_cnt[IW-1:0];
            if (ram_re) begin
              scan_cnt <= scan_cnt + CW'(1);
            end else if (!chk_vld) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (have_free) begin
            hit_idx <= free_idx;
            base    <= '0;
            claim   <= 1'b1;
            state   <= ST_WRITE;
          end else begin
            if (drop != 32'hFFFF_FFFF) begin
              drop <= drop + 32'd1;
            end
            state <= ST_FINISH;
          end
        end
        ST_WRITE: begin
          in_use[hit_idx] <= 1'b1;
          if (claim) begin
            used_cnt <= used_cnt + CW'(1);
          end
          res_acc <= 1'b1;
          res_idx <= hit_idx;
          res_val <= new_total;
          state   <= ST_FINISH;
        end
        ST_FINISH: begin
          if (fin_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    if (!rst && fin_go) begin
      out_data.accepted    <= res_acc;
      out_data.slot_index  <= res_idx_ext[3:0];
      out_data.slot_value  <= res_val;
      out_data.drop_total  <= drop;
      out_data.table_empty <= (used_cnt == '0);
    end
  end

  // The in-use count must be zero exactly when no in-use flag is set.
  `MSA_ASSERT_SAME(a_used_cnt_tracks_flags, 1'b1, ((used_cnt == '0) == (in_use == '0)))
  `MSA_ASSERT_NEXT(a_clear_empties, (state == ST_EXEC) && (op_r == OP_CLEAR),
                   (in_use == '0) && (drop == '0))
  `MSA_ASSERT_SAME(a_drop_monotonic, 1'b1,
                   (drop >= $past(drop)) || $past((state == ST_EXEC) && (op_r == OP_CLEAR)))
  `MSA_ASSERT_NEXT(a_scan_only_on_update, (state == ST_EXEC) && (op_r == OP_CLEAR),
                   state == ST_FINISH)

endmodule
`default_nettype wire
